/* rtl/multi_class_batch_ring_fifo_top_macros.svh */
// Assertion macros shared by the multi-class batch ring FIFO RTL.
`ifndef MULTI_CLASS_BATCH_RING_FIFO_TOP_MACROS_SVH
`define MULTI_CLASS_BATCH_RING_FIFO_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define MCBRF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mcbrf assertion failed");
// Next-cycle implication, checked out of reset.
`define MCBRF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mcbrf assertion failed");
`else
`define MCBRF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define MCBRF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* rtl/mcbrf_pkg.sv */
// Shared types and constants of the multi-class batch ring FIFO.
`timescale 1ns / 1ps
`default_nettype none
package mcbrf_pkg;

    // Fixed request and result field widths
    localparam int CLS_FIELD_W = 5;
    localparam int CNT_FIELD_W = 7;

    // Most pointers handed back for one remove request
    localparam int MAX_RESULTS = 64;

    // Batch tally saturates here
    localparam int TALLY_MAX = 127;

    // Request kinds carried on tuser
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Operations of the shared counter unit
    typedef enum logic [2:0] {
        ALU_INC_WRAP = 3'd0,
        ALU_INC_SAT  = 3'd1,
        ALU_SUB      = 3'd2,
        ALU_MIN      = 3'd3,
        ALU_LT       = 3'd4
    } alu_op_t;

endpackage
`default_nettype wire

/* rtl/multi_class_batch_ring_fifo_top.sv */
// Top level of the multi-class batch ring FIFO: sequencer, ring and class memories.
//
//  channel  | dir | tvalid/tready | tuser      | tlast      | tdata (low to high)
//  ---------+-----+---------------+------------+------------+----------------------------------
//  s_axis   | in  | request       | kind       | batch_last | class_index, pointer, request_count
//  m_axis   | out | result        | valid_res  | last       | out_pointer, accepted,
//           |     |               |            |            | batch_total, occupancy
//
// An insert passes the load, check, wpos, fill, tally and done states before its result is
// registered; a remove passes load, min, cap and occupancy, then read and send per returned
// pointer, set by the single-port ring memory and one shared counter unit used once per cycle.
// Reset clears the sequencer, the batch tally and the per-class valid bits; the
// block is ready in the first cycle after reset. A stalled result holds the
// sequencer; a new request is taken while the last result still waits.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_class_batch_ring_fifo_top_macros.svh"
module multi_class_batch_ring_fifo_top #(
    parameter int SLOTS    = 64,
    parameter int CLASSES  = 32,
    parameter int PTR_BITS = 48
) (
    input  logic aclk,
    input  logic aresetn,
    // Request channel
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // class_index[4:0], pointer, request_count[6:0]
    input  logic [((mcbrf_pkg::CLS_FIELD_W + PTR_BITS + mcbrf_pkg::CNT_FIELD_W + 7) / 8) * 8 - 1:0]
                 s_axis_tdata,
    // kind
    input  logic [0:0] s_axis_tuser,
    input  logic s_axis_tlast,
    // Result channel
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_pointer, accepted, batch_total[6:0], occupancy[6:0]
    output logic [((PTR_BITS + 1 + 2 * mcbrf_pkg::CNT_FIELD_W + 7) / 8) * 8 - 1:0]
                 m_axis_tdata,
    // valid_res
    output logic [0:0] m_axis_tuser,
    output logic m_axis_tlast
);
    import mcbrf_pkg::*;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ALU_W      = (CNT_W > CNT_FIELD_W) ? CNT_W : CNT_FIELD_W;
    localparam int CLS_W      = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int RING_DEPTH = CLASSES * SLOTS;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int CE_W       = 2 * SLOT_W + CNT_W;
    localparam int IN_PTR_LSB = CLS_FIELD_W;
    localparam int IN_REQ_LSB = CLS_FIELD_W + PTR_BITS;
    localparam int OUT_ACC    = PTR_BITS;
    localparam int OUT_TOT    = PTR_BITS + 1;
    localparam int OUT_OCC    = PTR_BITS + 1 + CNT_FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_I_CHECK,
        S_I_WPOS,
        S_I_FILL,
        S_I_TALLY,
        S_I_DONE,
        S_R_MIN,
        S_R_CAP,
        S_R_OCC,
        S_R_READ,
        S_R_SEND
    } state_t;

    // Sequencer registers
    state_t               state_reg, state_next;
    logic                 kind_reg, kind_next;
    logic                 blast_reg, blast_next;
    logic                 ok_reg, ok_next;
    logic [CLS_W-1:0]     cls_reg, cls_next;
    logic [PTR_BITS-1:0]  ptr_reg, ptr_next;
    logic [CNT_FIELD_W-1:0] req_reg, req_next;
    logic [SLOT_W-1:0]    wpos_reg, wpos_next;
    logic [SLOT_W-1:0]    rpos_reg, rpos_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [ALU_W-1:0]     n_reg, n_next;
    logic                 acc_reg, acc_next;
    logic [CNT_FIELD_W-1:0] tally_reg, tally_next;
    logic [RING_AW-1:0]   base_reg, base_next;

    // Result register
    logic                 m_valid_reg, m_valid_next;
    logic [PTR_BITS-1:0]  out_ptr_reg, out_ptr_next;
    logic                 out_vres_reg, out_vres_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_acc_reg, out_acc_next;
    logic [CNT_FIELD_W-1:0] out_tot_reg, out_tot_next;
    logic [CNT_FIELD_W-1:0] out_occ_reg, out_occ_next;

    // Memories and their read registers
    logic [PTR_BITS-1:0]  ring_mem [RING_DEPTH];
    logic [PTR_BITS-1:0]  ring_rd_reg;
    logic [CE_W-1:0]      class_mem [CLASSES];
    logic [CE_W-1:0]      class_rd_reg;
    logic                 class_vld_reg [CLASSES];
    logic                 class_vld_rd_reg;

    // Strobes and shared unit ports
    logic                 in_accept;
    logic                 out_free;
    logic [CLS_W-1:0]     in_cls;
    logic                 ring_we;
    logic                 ring_re;
    logic [RING_AW-1:0]   ring_addr;
    logic                 class_we;
    logic [CE_W-1:0]      class_wdata;
    alu_op_t              alu_op;
    logic [ALU_W-1:0]     alu_a;
    logic [ALU_W-1:0]     alu_b;
    logic [ALU_W-1:0]     alu_y;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign in_cls        = CLS_W'(s_axis_tdata[CLS_FIELD_W-1:0]);

    mcbrf_alu #(
        .W (ALU_W)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // Step the sequencer, drive the shared unit and the memory strobes
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        blast_next    = blast_reg;
        ok_next       = ok_reg;
        cls_next      = cls_reg;
        ptr_next      = ptr_reg;
        req_next      = req_reg;
        wpos_next     = wpos_reg;
        rpos_next     = rpos_reg;
        fill_next     = fill_reg;
        occ_next      = occ_reg;
        n_next        = n_reg;
        acc_next      = acc_reg;
        tally_next    = tally_reg;
        base_next     = base_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        out_ptr_next  = out_ptr_reg;
        out_vres_next = out_vres_reg;
        out_last_next = out_last_reg;
        out_acc_next  = out_acc_reg;
        out_tot_next  = out_tot_reg;
        out_occ_next  = out_occ_reg;
        ring_we       = 1'b0;
        ring_re       = 1'b0;
        class_we      = 1'b0;
        class_wdata   = {wpos_reg, rpos_reg, fill_reg};
        alu_op        = ALU_SUB;
        alu_a         = '0;
        alu_b         = '0;

        unique case (state_reg)
            S_IDLE: begin
                // Capture the request; class state is read at this edge
                if (in_accept) begin
                    kind_next  = s_axis_tuser[0];
                    blast_next = s_axis_tlast;
                    ok_next    = int'(s_axis_tdata[CLS_FIELD_W-1:0]) < CLASSES;
                    cls_next   = in_cls;
                    ptr_next   = s_axis_tdata[IN_PTR_LSB +: PTR_BITS];
                    req_next   = s_axis_tdata[IN_REQ_LSB +: CNT_FIELD_W];
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                // Unwritten or out-of-range classes read as empty
                if (ok_reg && class_vld_rd_reg) begin
                    {wpos_next, rpos_next, fill_next} = class_rd_reg;
                end else begin
                    wpos_next = '0;
                    rpos_next = '0;
                    fill_next = '0;
                end
                base_next  = RING_AW'(RING_AW'(cls_reg) * RING_AW'(SLOTS));
                state_next = (kind_reg == KIND_INSERT) ? S_I_CHECK : S_R_MIN;
            end
            S_I_CHECK: begin
                // Store the pointer while the ring has room
                alu_op     = ALU_LT;
                alu_a      = ALU_W'(fill_reg);
                alu_b      = ALU_W'(SLOTS);
                acc_next   = ok_reg && alu_y[0];
                ring_we    = ok_reg && alu_y[0];
                state_next = S_I_WPOS;
            end
            S_I_WPOS: begin
                alu_op = ALU_INC_WRAP;
                alu_a  = ALU_W'(wpos_reg);
                alu_b  = ALU_W'(SLOTS);
                if (acc_reg) begin
                    wpos_next = SLOT_W'(alu_y);
                end
                state_next = S_I_FILL;
            end
            S_I_FILL: begin
                alu_op = ALU_INC_SAT;
                alu_a  = ALU_W'(fill_reg);
                alu_b  = ALU_W'(SLOTS);
                if (acc_reg) begin
                    fill_next = CNT_W'(alu_y);
                end
                state_next = S_I_TALLY;
            end
            S_I_TALLY: begin
                alu_op = ALU_INC_SAT;
                alu_a  = ALU_W'(tally_reg);
                alu_b  = ALU_W'(TALLY_MAX);
                if (acc_reg) begin
                    tally_next = CNT_FIELD_W'(alu_y);
                end
                state_next = S_I_DONE;
            end
            S_I_DONE: begin
                // Write back class state and report the insert
                if (out_free) begin
                    class_we      = ok_reg;
                    m_valid_next  = 1'b1;
                    out_ptr_next  = '0;
                    out_vres_next = 1'b0;
                    out_last_next = 1'b1;
                    out_acc_next  = acc_reg;
                    out_tot_next  = blast_reg ? tally_reg : '0;
                    out_occ_next  = CNT_FIELD_W'(fill_reg);
                    if (blast_reg) begin
                        tally_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_R_MIN: begin
                alu_op     = ALU_MIN;
                alu_a      = ALU_W'(req_reg);
                alu_b      = ALU_W'(fill_reg);
                n_next     = alu_y;
                state_next = S_R_CAP;
            end
            S_R_CAP: begin
                alu_op     = ALU_MIN;
                alu_a      = n_reg;
                alu_b      = ALU_W'(MAX_RESULTS);
                n_next     = alu_y;
                state_next = S_R_OCC;
            end
            S_R_OCC: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(fill_reg);
                alu_b  = n_reg;
                if (n_reg == '0) begin
                    // Nothing to hand back: one not-valid result
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        out_ptr_next  = '0;
                        out_vres_next = 1'b0;
                        out_last_next = 1'b1;
                        out_acc_next  = 1'b0;
                        out_tot_next  = '0;
                        out_occ_next  = CNT_FIELD_W'(fill_reg);
                        state_next    = S_IDLE;
                    end
                end else begin
                    occ_next   = CNT_W'(alu_y);
                    state_next = S_R_READ;
                end
            end
            S_R_READ: begin
                // Fetch the head pointer and advance the read position
                ring_re    = 1'b1;
                alu_op     = ALU_INC_WRAP;
                alu_a      = ALU_W'(rpos_reg);
                alu_b      = ALU_W'(SLOTS);
                rpos_next  = SLOT_W'(alu_y);
                state_next = S_R_SEND;
            end
            S_R_SEND: begin
                alu_op = ALU_SUB;
                alu_a  = n_reg;
                alu_b  = ALU_W'(1);
                class_wdata = {wpos_reg, rpos_reg, occ_reg};
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_ptr_next  = ring_rd_reg;
                    out_vres_next = 1'b1;
                    out_last_next = (n_reg == ALU_W'(1));
                    out_acc_next  = 1'b0;
                    out_tot_next  = '0;
                    out_occ_next  = CNT_FIELD_W'(occ_reg);
                    n_next        = alu_y;
                    if (n_reg == ALU_W'(1)) begin
                        class_we   = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_R_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pick the ring slot for the current access
    always_comb begin
        if (state_reg == S_R_READ) begin
            ring_addr = base_reg + RING_AW'(rpos_reg);
        end else begin
            ring_addr = base_reg + RING_AW'(wpos_reg);
        end
    end

    // Hold sequencer state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            tally_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tally_reg   <= tally_next;
        end
        kind_reg     <= kind_next;
        blast_reg    <= blast_next;
        ok_reg       <= ok_next;
        cls_reg      <= cls_next;
        ptr_reg      <= ptr_next;
        req_reg      <= req_next;
        wpos_reg     <= wpos_next;
        rpos_reg     <= rpos_next;
        fill_reg     <= fill_next;
        occ_reg      <= occ_next;
        n_reg        <= n_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        out_ptr_reg  <= out_ptr_next;
        out_vres_reg <= out_vres_next;
        out_last_reg <= out_last_next;
        out_acc_reg  <= out_acc_next;
        out_tot_reg  <= out_tot_next;
        out_occ_reg  <= out_occ_next;
    end

    // Ring store: one access per cycle, registered read
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_addr] <= ptr_reg;
        end
        if (ring_re) begin
            ring_rd_reg <= ring_mem[ring_addr];
        end
    end

    // Per-class positions and fill, read on request acceptance
    always_ff @(posedge aclk) begin
        if (class_we) begin
            class_mem[cls_reg] <= class_wdata;
        end
        if (in_accept) begin
            class_rd_reg <= class_mem[in_cls];
        end
    end

    // Valid bits: a class never written reads as empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CLASSES; i++) begin
                class_vld_reg[i] <= 1'b0;
            end
        end else if (class_we) begin
            class_vld_reg[cls_reg] <= 1'b1;
        end
        if (in_accept) begin
            class_vld_rd_reg <= class_vld_reg[in_cls];
        end
    end

    // Pack the result channel
    always_comb begin
        m_axis_tdata                          = '0;
        m_axis_tdata[PTR_BITS-1:0]            = out_ptr_reg;
        m_axis_tdata[OUT_ACC]                 = out_acc_reg;
        m_axis_tdata[OUT_TOT +: CNT_FIELD_W]  = out_tot_reg;
        m_axis_tdata[OUT_OCC +: CNT_FIELD_W]  = out_occ_reg;
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tuser[0] = out_vres_reg;
    assign m_axis_tlast    = out_last_reg;

    `MCBRF_ASSERT_IMPL(a_fill_bound, aclk, aresetn, class_we, int'(class_wdata[CNT_W-1:0]) <= SLOTS)
    `MCBRF_ASSERT_IMPL(a_ptr_not_acc, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], !out_acc_reg)
    `MCBRF_ASSERT_IMPL(a_send_nonzero, aclk, aresetn, state_reg == S_R_SEND, n_reg != '0)
    `MCBRF_ASSERT_NEXT(a_accept_loads, aclk, aresetn, in_accept, state_reg == S_LOAD)

endmodule
`default_nettype wire

/* rtl/mcbrf_alu.sv */
// Shared counter unit: wrap/saturate increment, subtract, minimum, compare.
`timescale 1ns / 1ps
`default_nettype none
module mcbrf_alu #(
    parameter int W = 7
) (
    input  mcbrf_pkg::alu_op_t op,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    output logic [W-1:0]       y
);
    import mcbrf_pkg::*;

    logic [W-1:0] a_inc;
    logic         a_lt_b;

    assign a_inc  = a + W'(1);
    assign a_lt_b = (a < b);

    // Pick the result of the requested operation
    always_comb begin
        case (op)
            ALU_INC_WRAP: y = (a_inc == b) ? '0 : a_inc;
            ALU_INC_SAT:  y = (a == b) ? a : a_inc;
            ALU_SUB:      y = a - b;
            ALU_MIN:      y = a_lt_b ? a : b;
            ALU_LT:       y = {{(W-1){1'b0}}, a_lt_b};
            default:      y = '0;
        endcase
    end

endmodule
`default_nettype wire
